@@ rtl/mtsl_pkg.sv @@
package mtsl_pkg;

  // Width of one stored value and of the merged output value.
  localparam int unsigned DataW = 32;

  // Item codes on the action field; the remaining code is ignored.
  typedef enum logic [1:0] {
    ACT_APPEND_A = 2'd0,
    ACT_APPEND_B = 2'd1,
    ACT_MERGE    = 2'd2
  } action_e;

  // Merge sequencer states.
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_e;

  // One merged beat as it leaves the sequencer.
  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] value;
    logic                    from_list;
    logic                    last;
    logic                    overflow;
  } result_t;

endpackage

@@ rtl/mtsl_list_mem.sv @@
module mtsl_list_mem #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic signed [mtsl_pkg::DataW-1:0]    wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic signed [mtsl_pkg::DataW-1:0]    rdata_o
);

  logic signed [mtsl_pkg::DataW-1:0] mem_q [DEPTH];
  logic signed [mtsl_pkg::DataW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mtsl_merge_ctrl.sv @@
module mtsl_merge_ctrl #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [1:0]                           action_i,
  input  logic signed [mtsl_pkg::DataW-1:0]    value_i,
  output logic                                 busy_o,
  output logic signed [mtsl_pkg::DataW-1:0]    wdata_o,
  output logic                                 a_we_o,
  output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] a_waddr_o,
  output logic                                 a_re_o,
  output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] a_raddr_o,
  input  logic signed [mtsl_pkg::DataW-1:0]    a_rdata_i,
  output logic                                 b_we_o,
  output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] b_waddr_o,
  output logic                                 b_re_o,
  output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] b_raddr_o,
  input  logic signed [mtsl_pkg::DataW-1:0]    b_rdata_i,
  output mtsl_pkg::result_t                    emit_o
);

  localparam int unsigned AddrW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(LIST_DEPTH + 1);
  localparam logic [CntW-1:0] Cap = CntW'(LIST_DEPTH);

  mtsl_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CntW-1:0]  ia_q, ia_d, ib_q, ib_d;
  logic             drop_q, drop_d;

  logic [CntW-1:0]  ia_nx, ib_nx;
  logic             a_empty, b_empty, take_b, done;

  // Head pointers step by one past the value just taken.
  assign ia_nx   = ia_q + CntW'(1);
  assign ib_nx   = ib_q + CntW'(1);
  assign a_empty = (ia_q == cnt_a_q);
  assign b_empty = (ib_q == cnt_b_q);
  // On a tie the head of list B goes first.
  assign take_b  = a_empty || (!b_empty && !(a_rdata_i < b_rdata_i));

  assign busy_o  = (state_q != mtsl_pkg::ST_IDLE);
  assign wdata_o = value_i;
  assign a_waddr_o = cnt_a_q[AddrW-1:0];
  assign b_waddr_o = cnt_b_q[AddrW-1:0];

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtsl_pkg::ST_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ia_q    <= '0;
      ib_q    <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      ia_q    <= ia_d;
      ib_q    <= ib_d;
      drop_q  <= drop_d;
    end
  end

  // Appends write at the fill count; a merge reads one head per beat.
  // The head of the list not taken stays in its read register, and the
  // taken list's next entry is read so it is ready on the next beat.
  always_comb begin
    state_d   = state_q;
    cnt_a_d   = cnt_a_q;
    cnt_b_d   = cnt_b_q;
    ia_d      = ia_q;
    ib_d      = ib_q;
    drop_d    = drop_q;
    a_we_o    = 1'b0;
    b_we_o    = 1'b0;
    a_re_o    = 1'b0;
    b_re_o    = 1'b0;
    a_raddr_o = '0;
    b_raddr_o = '0;
    done      = 1'b0;
    emit_o    = '0;

    unique case (state_q)
      mtsl_pkg::ST_IDLE: begin
        if (start_i) begin
          case (action_i)
            mtsl_pkg::ACT_APPEND_A: begin
              if (cnt_a_q < Cap) begin
                a_we_o  = 1'b1;
                cnt_a_d = cnt_a_q + CntW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            mtsl_pkg::ACT_APPEND_B: begin
              if (cnt_b_q < Cap) begin
                b_we_o  = 1'b1;
                cnt_b_d = cnt_b_q + CntW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            mtsl_pkg::ACT_MERGE: begin
              if ((cnt_a_q == '0) && (cnt_b_q == '0)) begin
                drop_d = 1'b0;
              end else begin
                a_re_o  = 1'b1;
                b_re_o  = 1'b1;
                ia_d    = '0;
                ib_d    = '0;
                state_d = mtsl_pkg::ST_MERGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      mtsl_pkg::ST_MERGE: begin
        emit_o.valid     = 1'b1;
        emit_o.from_list = take_b;
        emit_o.overflow  = drop_q;
        if (take_b) begin
          emit_o.value = b_rdata_i;
          ib_d         = ib_nx;
          b_re_o       = 1'b1;
          b_raddr_o    = ib_nx[AddrW-1:0];
          done         = a_empty && (ib_nx == cnt_b_q);
        end else begin
          emit_o.value = a_rdata_i;
          ia_d         = ia_nx;
          a_re_o       = 1'b1;
          a_raddr_o    = ia_nx[AddrW-1:0];
          done         = b_empty && (ia_nx == cnt_a_q);
        end
        emit_o.last = done;
        if (done) begin
          state_d = mtsl_pkg::ST_IDLE;
          cnt_a_d = '0;
          cnt_b_d = '0;
          drop_d  = 1'b0;
        end
      end
      default: begin
        state_d = mtsl_pkg::ST_IDLE;
      end
    endcase
  end

  // Memories are written only while no merge runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !(a_we_o || b_we_o))
    else $error("list write during merge");

  // The final merged beat returns the sequencer to idle with empty lists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && emit_o.last) |=> (!busy_o && cnt_a_q == '0 && cnt_b_q == '0))
    else $error("merge did not finish cleanly");

  // Fill counts never pass the list capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= Cap) && (cnt_b_q <= Cap))
    else $error("fill count beyond capacity");

  // A merge starts only from an accepted merge item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && action_i == mtsl_pkg::ACT_MERGE))
    else $error("merge started without a merge item");

  // Head pointers stay within the fill counts during a merge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> ((ia_q <= cnt_a_q) && (ib_q <= cnt_b_q) && !(a_empty && b_empty)))
    else $error("head pointer past fill count");

endmodule

@@ rtl/merge_two_sorted_lists.sv @@
// Two-way merge of two ascending lists of signed 32-bit values.
// Input: an item is taken at a rising edge with start_i high and busy_o low.
// Action 0 appends value_i to list A, action 1 to list B, action 2 merges;
// action 3 is ignored. An append leaves busy_o low, so appends may follow
// each other every cycle. An append to a full list is dropped and sets the
// overflow flag reported on the next merge. A merge of N held values raises
// busy_o while its N beats are chosen: the accepting cycle reads both list
// heads from their RAMs, then one value leaves per cycle, as the list RAMs
// have registered reads and the chosen list's next entry is read while the
// current head is emitted. Each beat appears on valid_o in the cycle after
// it is chosen; the first is chosen once the sequencer has entered its
// merge state. Ties go to list B. last_o marks the final beat; afterwards
// both lists are empty and the overflow flag is clear. A merge of two empty
// lists emits nothing and only clears the flag.
// Results are shown for exactly one cycle with valid_o high; the receiver
// must take every beat, as there is no back-pressure.
// Reset empties both lists and clears the flag; RAM contents are not reset.
module merge_two_sorted_lists #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        action_i,
  input  logic signed [mtsl_pkg::DataW-1:0] value_i,
  output logic                              valid_o,
  output logic signed [mtsl_pkg::DataW-1:0] merged_value_o,
  output logic                              from_list_o,
  output logic                              last_o,
  output logic                              overflow_o
);

  localparam int unsigned AddrW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic signed [mtsl_pkg::DataW-1:0] wdata;
  logic                              a_we, a_re, b_we, b_re;
  logic [AddrW-1:0]                  a_waddr, a_raddr, b_waddr, b_raddr;
  logic signed [mtsl_pkg::DataW-1:0] a_rdata, b_rdata;
  mtsl_pkg::result_t                 emit;

  logic                              valid_q;
  logic signed [mtsl_pkg::DataW-1:0] value_q;
  logic                              from_q, last_q, ovf_q;

  mtsl_list_mem #(.DEPTH(LIST_DEPTH)) u_mem_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (wdata),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mtsl_list_mem #(.DEPTH(LIST_DEPTH)) u_mem_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mtsl_merge_ctrl #(.LIST_DEPTH(LIST_DEPTH)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .action_i  (action_i),
    .value_i   (value_i),
    .busy_o    (busy_o),
    .wdata_o   (wdata),
    .a_we_o    (a_we),
    .a_waddr_o (a_waddr),
    .a_re_o    (a_re),
    .a_raddr_o (a_raddr),
    .a_rdata_i (a_rdata),
    .b_we_o    (b_we),
    .b_waddr_o (b_waddr),
    .b_re_o    (b_re),
    .b_raddr_o (b_raddr),
    .b_rdata_i (b_rdata),
    .emit_o    (emit)
  );

  // Result strobe register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit.valid;
    end
  end

  // Result payload register; loaded only on a merged beat.
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      value_q <= emit.value;
      from_q  <= emit.from_list;
      last_q  <= emit.last;
      ovf_q   <= emit.overflow;
    end
  end

  assign valid_o        = valid_q;
  assign merged_value_o = value_q;
  assign from_list_o    = from_q;
  assign last_o         = last_q;
  assign overflow_o     = ovf_q;

endmodule

@@ tb/tb_merge_two_sorted_lists.sv @@
`timescale 1ns / 1ps

module tb_merge_two_sorted_lists;

  localparam int unsigned ListDepth = 32;
  localparam int ItemTarget = 360;
  localparam int StallLimit = 400;
  localparam int DrainCycles = 8;
  localparam int ValMin = 32'sh8000_0000;
  localparam int ValMax = 32'sh7fff_ffff;
  // The one action code the block ignores.
  localparam logic [1:0] ActUnused = 2'd3;

  typedef struct {
    logic signed [mtsl_pkg::DataW-1:0] value;
    logic                              from_list;
    logic                              last;
    logic                              overflow;
  } merged_beat_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start_i;
  logic                              busy_o;
  logic [1:0]                        action_i;
  logic signed [mtsl_pkg::DataW-1:0] value_i;
  logic                              valid_o;
  logic signed [mtsl_pkg::DataW-1:0] merged_value_o;
  logic                              from_list_o;
  logic                              last_o;
  logic                              overflow_o;

  // Shadow copy of the two lists and the drop flag.
  int           shadow_a[$];
  int           shadow_b[$];
  bit           shadow_dropped;
  merged_beat_t pending_beats[$];

  int items_sent;
  int merges_done;
  int empty_merges;
  int overflow_merges;
  int beats_checked;
  int error_count;
  int stall_cycles;
  int idle_mode;

  merge_two_sorted_lists #(
    .LIST_DEPTH(ListDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .value_i        (value_i),
    .valid_o        (valid_o),
    .merged_value_o (merged_value_o),
    .from_list_o    (from_list_o),
    .last_o         (last_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Emit the merged order of the shadow lists; ties take list B first.
  function automatic void predict_merge();
    int ia;
    int ib;
    int total;
    merged_beat_t beat;
    ia = 0;
    ib = 0;
    total = shadow_a.size() + shadow_b.size();
    for (int k = 0; k < total; k++) begin
      if (ia >= shadow_a.size()) begin
        beat.value = shadow_b[ib];
        beat.from_list = 1'b1;
        ib++;
      end else if (ib >= shadow_b.size() || shadow_a[ia] < shadow_b[ib]) begin
        beat.value = shadow_a[ia];
        beat.from_list = 1'b0;
        ia++;
      end else begin
        beat.value = shadow_b[ib];
        beat.from_list = 1'b1;
        ib++;
      end
      beat.last = (k == total - 1);
      beat.overflow = shadow_dropped;
      pending_beats.push_back(beat);
    end
    merges_done++;
    if (total == 0) empty_merges++;
    if (shadow_dropped && total != 0) overflow_merges++;
    shadow_a.delete();
    shadow_b.delete();
    shadow_dropped = 1'b0;
  endfunction

  // Update the shadow state for one accepted item.
  function automatic void predict_item(logic [1:0] act, int val);
    case (act)
      mtsl_pkg::ACT_APPEND_A: begin
        if (shadow_a.size() < ListDepth) shadow_a.push_back(val);
        else shadow_dropped = 1'b1;
      end
      mtsl_pkg::ACT_APPEND_B: begin
        if (shadow_b.size() < ListDepth) shadow_b.push_back(val);
        else shadow_dropped = 1'b1;
      end
      mtsl_pkg::ACT_MERGE: predict_merge();
      default: ;
    endcase
  endfunction

  // Sender idle cycles before the next item, shaped by the current mode.
  function automatic int draw_gap();
    case (idle_mode)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  function automatic int rand_value(int style);
    case (style)
      0: return int'($urandom);
      1: return int'($urandom_range(0, 6)) - 3;
      default: begin
        if ($urandom_range(0, 1) == 1) return ValMin + int'($urandom_range(0, 3));
        return ValMax - int'($urandom_range(0, 3));
      end
    endcase
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(input logic [1:0] act, input int val);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      start_i  <= 1'b0;
      action_i <= 2'($urandom);
      value_i  <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    action_i <= act;
    value_i  <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_item(act, val);
    if (act != ActUnused) items_sent++;
  endtask

  // Hold the sender off until every predicted beat has come out.
  task automatic wait_drained();
    if (pending_beats.size() != 0) begin
      start_i <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clk_i);
    end
  endtask

  // Load two lists with interleaved appends; style 3 leaves them unsorted, and noisy mixes in ignored items and merges.
  task automatic load_lists(input int na, input int nb, input int style, input bit noisy);
    int vals_a[$];
    int vals_b[$];
    int ia;
    int ib;
    bit pick_a;
    for (int i = 0; i < na; i++) vals_a.push_back(rand_value(style % 3));
    for (int i = 0; i < nb; i++) vals_b.push_back(rand_value(style % 3));
    if (style != 3) begin
      vals_a.sort();
      vals_b.sort();
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (noisy && $urandom_range(0, 11) == 0) send_item(ActUnused, rand_value(0));
      if (noisy && $urandom_range(0, 19) == 0) send_item(mtsl_pkg::ACT_MERGE, rand_value(0));
      pick_a = (ib >= nb) || (ia < na && $urandom_range(0, 1) == 1);
      if (pick_a) begin
        send_item(mtsl_pkg::ACT_APPEND_A, vals_a[ia]);
        ia++;
      end else begin
        send_item(mtsl_pkg::ACT_APPEND_B, vals_b[ib]);
        ib++;
      end
    end
  endtask

  task automatic test_empty_merge();
    idle_mode = 2;
    send_item(mtsl_pkg::ACT_MERGE, ValMax);
    send_item(mtsl_pkg::ACT_MERGE, 0);
  endtask

  // Both extremes and zero in both lists, so every tie goes to list B.
  task automatic test_extremes();
    idle_mode = 1;
    send_item(mtsl_pkg::ACT_APPEND_A, ValMin);
    send_item(mtsl_pkg::ACT_APPEND_B, ValMin);
    send_item(mtsl_pkg::ACT_APPEND_A, -1);
    send_item(mtsl_pkg::ACT_APPEND_A, 0);
    send_item(mtsl_pkg::ACT_APPEND_B, 0);
    send_item(mtsl_pkg::ACT_APPEND_B, ValMax);
    send_item(mtsl_pkg::ACT_APPEND_A, ValMax);
    send_item(mtsl_pkg::ACT_MERGE, ValMin);
  endtask

  // One list empty while the other holds a single value.
  task automatic test_one_sided();
    idle_mode = 0;
    send_item(mtsl_pkg::ACT_APPEND_A, 32'sh5555_5555);
    send_item(mtsl_pkg::ACT_MERGE, 0);
    send_item(mtsl_pkg::ACT_APPEND_B, 32'shAAAA_AAAA);
    send_item(mtsl_pkg::ACT_MERGE, -1);
  endtask

  task automatic test_unused_action();
    idle_mode = 2;
    send_item(ActUnused, -1);
    send_item(mtsl_pkg::ACT_APPEND_B, 7);
    send_item(ActUnused, 3);
    send_item(mtsl_pkg::ACT_MERGE, 0);
  endtask

  // Out-of-order lists still follow the head-by-head rule.
  task automatic test_unsorted();
    idle_mode = 1;
    send_item(mtsl_pkg::ACT_APPEND_A, 5);
    send_item(mtsl_pkg::ACT_APPEND_A, -3);
    send_item(mtsl_pkg::ACT_APPEND_B, 1);
    send_item(mtsl_pkg::ACT_APPEND_B, 0);
    send_item(mtsl_pkg::ACT_MERGE, 0);
  endtask

  // Overfill both lists so that the merge carries the overflow flag on
  // the longest possible run, then pause until it has all come out.
  task automatic test_full_lists();
    idle_mode = 2;
    load_lists(ListDepth + 2, ListDepth + 1, $urandom_range(0, 2), 1'b0);
    send_item(mtsl_pkg::ACT_MERGE, rand_value(0));
    wait_drained();
  endtask

  task automatic test_random_merges();
    int shape;
    int na;
    int nb;
    while (items_sent < ItemTarget) begin
      shape = $urandom_range(0, 9);
      idle_mode = $urandom_range(0, 2);
      if (shape == 9) begin
        na = $urandom_range(ListDepth - 2, ListDepth + 3);
        nb = $urandom_range(0, ListDepth + 2);
      end else begin
        na = $urandom_range(0, 6);
        nb = $urandom_range(0, 6);
      end
      // Mostly well-formed sorted lists; now and then unsorted ones.
      load_lists(na, nb, ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2), 1'b1);
      send_item(mtsl_pkg::ACT_MERGE, rand_value(0));
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  // Compare each beat with the oldest prediction.
  always @(posedge clk_i) begin : check_beats
    merged_beat_t exp_beat;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_beats.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected beat: value %0d from %0b last %0b overflow %0b",
                   merged_value_o, from_list_o, last_o, overflow_o);
      end else begin
        exp_beat = pending_beats.pop_front();
        beats_checked++;
        if (merged_value_o !== exp_beat.value || from_list_o !== exp_beat.from_list ||
            last_o !== exp_beat.last || overflow_o !== exp_beat.overflow) begin
          error_count++;
          if (error_count <= 10)
            $display("beat mismatch: expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                     exp_beat.value, exp_beat.from_list, exp_beat.last,
                     exp_beat.overflow, merged_value_o, from_list_o, last_o,
                     overflow_o);
        end
      end
    end
  end

  // Ends the run if neither an item nor a beat moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && busy_o === 1'b0) || valid_o === 1'b1) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni   <= 1'b0;
    start_i  <= 1'b0;
    action_i <= ActUnused;
    value_i  <= '0;
    shadow_dropped = 1'b0;
    items_sent = 0;
    merges_done = 0;
    empty_merges = 0;
    overflow_merges = 0;
    beats_checked = 0;
    error_count = 0;
    stall_cycles = 0;
    idle_mode = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_merge();
    test_extremes();
    test_one_sided();
    test_unused_action();
    test_unsorted();
    test_full_lists();
    test_random_merges();

    wait_drained();
    start_i <= 1'b0;
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d items in %0d merges (%0d empty, %0d with dropped appends).",
             items_sent, merges_done, empty_merges, overflow_merges);
    $display("Checked %0d merged beats, %0d mismatches.", beats_checked, error_count);
    if (error_count == 0 && pending_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
